>>> src/dasg_pkg.sv
// shared types and constants for the diagonal area scan generator
// used by dasg_ctrl, dasg_datapath and the top level; no dependencies
`default_nettype none

package dasg_pkg;

  localparam int MAX_LOG_SIDE_DEF = 12;
  localparam int LOG_SIDE_MIN     = 6;
  localparam int TILE_W           = 24;
  localparam int LOG_REG_W        = 4;
  localparam int CFG_IDX_W        = 2;
  localparam logic [LOG_REG_W-1:0] LOG_RESET = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_LOG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_LOG_HEIGHT = 2'd1;

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_STEP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic start;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic req_type;
    logic active;
    logic step_hit;
    logic step_end;
  } status_t;

endpackage

`default_nettype wire

>>> src/dasg_ctrl.sv
// controller state machine: handshakes and sequencing of start and advance
// depends on dasg_pkg
`default_nettype none

module dasg_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire               out_ready,
  input  dasg_pkg::status_t status,
  output dasg_pkg::cmd_t    cmd
);
  import dasg_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.req_type == REQ_START) begin
          cmd.start  = 1'b1;
          state_next = ST_OUT;
        end else if (!status.active) begin
          cmd.finish = 1'b1;
          state_next = ST_OUT;
        end else begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        // one move per cycle until a tile inside the map or the end
        cmd.step = 1'b1;
        if (status.step_end || status.step_hit) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        if (out_ready) begin
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_next  = ST_DECIDE;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> src/dasg_datapath.sv
// datapath: map size registers, scan geometry, position walk and result register
// depends on dasg_pkg
`default_nettype none

module dasg_datapath #(
  parameter int MAX_LOG_SIDE = dasg_pkg::MAX_LOG_SIDE_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_wr_en,
  input  wire [dasg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [dasg_pkg::LOG_REG_W-1:0]  cfg_data,
  input  wire                            req_type,
  input  wire [dasg_pkg::TILE_W-1:0]     corner_first,
  input  wire [dasg_pkg::TILE_W-1:0]     corner_second,
  input  dasg_pkg::cmd_t                 cmd,
  output dasg_pkg::status_t              status,
  output logic [dasg_pkg::TILE_W-1:0]    tile_index,
  output logic                           done_res
);
  import dasg_pkg::*;

  localparam int LW_W = $clog2(MAX_LOG_SIDE + 1);
  localparam int CW   = MAX_LOG_SIDE;      // coordinate inside the map
  localparam int PW   = MAX_LOG_SIDE + 3;  // walk position, may leave the map
  localparam int WW   = MAX_LOG_SIDE + 3;  // corner sums and differences
  localparam int RSW  = MAX_LOG_SIDE + 2;  // row step
  localparam int RLW  = MAX_LOG_SIDE + 1;  // row length
  localparam int RCW  = MAX_LOG_SIDE + 2;  // row count

  // map size registers
  logic [LOG_REG_W-1:0] map_log_width, map_log_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_log_width  <= LOG_RESET;
      map_log_height <= LOG_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MAP_LOG_WIDTH:  map_log_width  <= cfg_data;
        REG_MAP_LOG_HEIGHT: map_log_height <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [LW_W-1:0] eff_log(input logic [LOG_REG_W-1:0] v);
    logic [LW_W-1:0] r;
    if (int'(v) < LOG_SIDE_MIN) r = LW_W'(LOG_SIDE_MIN);
    else if (int'(v) > MAX_LOG_SIDE) r = LW_W'(MAX_LOG_SIDE);
    else r = LW_W'(v);
    return r;
  endfunction

  logic [LW_W-1:0] lw, lh;
  assign lw = eff_log(map_log_width);
  assign lh = eff_log(map_log_height);

  // captured item
  logic              req_q;
  logic [TILE_W-1:0] c1_q, c2_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_type;
      c1_q  <= corner_first;
      c2_q  <= corner_second;
    end
  end

  // scan state
  logic signed [PW-1:0]  pos_x, pos_y;
  logic signed [1:0]     diag_step;
  logic signed [RSW-1:0] row_step_x, row_step_y;
  logic [RLW-1:0]        row_length, left_in_row;
  logic [RCW-1:0]        rows_left;
  logic                  odd_area;
  logic                  scan_active;

  // start geometry
  logic [TILE_W-1:0] xm, ym;
  logic [CW-1:0]     x1, y1, x2, y2;
  logic signed [WW-1:0] dx, dy, w, h, w_abs, h_abs;
  logic              w_pos, w_neg, h_neg;
  logic [RLW-1:0]    half_w;
  logic [RCW-1:0]    s_rows;
  logic signed [RSW-1:0] half_ext, s_rsx, s_rsy;
  logic signed [1:0] s_diag;

  always_comb begin
    xm = (TILE_W'(1) << lw) - TILE_W'(1);
    ym = (TILE_W'(1) << lh) - TILE_W'(1);
    x1 = CW'(c1_q & xm);
    y1 = CW'((c1_q >> lw) & ym);
    x2 = CW'(c2_q & xm);
    y2 = CW'((c2_q >> lw) & ym);
    dx = WW'(x1) - WW'(x2);
    dy = WW'(y1) - WW'(y2);
    w  = dx + dy;
    h  = dy - dx;
    w_neg = w[WW-1];
    w_pos = !w[WW-1] && (w != '0);
    h_neg = h[WW-1];
    w_abs = w_neg ? -w : w;
    h_abs = h_neg ? -h : h;
    half_w   = RLW'(w_abs >> 1);
    half_ext = RSW'(half_w);
    if (w_pos) begin
      s_diag = 2'sd1;
      s_rsx  = (h_neg ? RSW'(1) : RSW'(0)) - half_ext;
      s_rsy  = (h_neg ? RSW'(0) : RSW'(1)) - half_ext;
      s_rows = RCW'(h_abs);
    end else if (w_neg) begin
      s_diag = -2'sd1;
      s_rsx  = (h_neg ? RSW'(0) : {RSW{1'b1}}) + half_ext;
      s_rsy  = (h_neg ? {RSW{1'b1}} : RSW'(0)) + half_ext;
      s_rows = RCW'(h_abs);
    end else begin
      // corners on one anti-diagonal: single diagonal walk
      s_diag = 2'sd0;
      s_rsy  = h_neg ? {RSW{1'b1}} : RSW'(1);
      s_rsx  = -s_rsy;
      s_rows = RCW'(h_abs >> 1);
    end
  end

  // one advance move
  logic signed [PW-1:0] diag_ext, rsx_ext, rsy_ext, nx, ny;
  logic [RLW-1:0]       n_left;
  logic [RCW-1:0]       n_rows;
  logic                 n_end, n_hit;

  always_comb begin
    diag_ext = {{(PW-2){diag_step[1]}}, diag_step};
    rsx_ext  = {{(PW-RSW){row_step_x[RSW-1]}}, row_step_x};
    rsy_ext  = {{(PW-RSW){row_step_y[RSW-1]}}, row_step_y};
    nx     = pos_x;
    ny     = pos_y;
    n_left = left_in_row;
    n_rows = rows_left;
    n_end  = 1'b0;
    if (left_in_row != '0) begin
      n_left = left_in_row - RLW'(1);
      nx     = pos_x + diag_ext;
      ny     = pos_y + diag_ext;
    end else if (rows_left != '0) begin
      n_rows = rows_left - RCW'(1);
      n_left = row_length;
      nx     = pos_x + rsx_ext;
      ny     = pos_y + rsy_ext;
      if (n_rows[0]) begin
        // odd row: shifted start in an odd area, one tile less otherwise
        if (odd_area) begin
          nx = pos_x + rsx_ext - diag_ext;
          ny = pos_y + rsy_ext - diag_ext;
        end else if (row_length != '0) begin
          n_left = row_length - RLW'(1);
        end
      end
    end else begin
      n_end = 1'b1;
    end
    n_hit = !n_end && !nx[PW-1] && !ny[PW-1]
            && ((PW'(nx) >> lw) == '0) && ((PW'(ny) >> lh) == '0);
  end

  function automatic logic [TILE_W-1:0] make_tile(input logic [CW-1:0] x,
                                                  input logic [CW-1:0] y,
                                                  input logic [LW_W-1:0] l);
    return (TILE_W'(y) << l) | TILE_W'(x);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active <= 1'b0;
      pos_x       <= '0;
      pos_y       <= '0;
      diag_step   <= '0;
      row_step_x  <= '0;
      row_step_y  <= '0;
      row_length  <= '0;
      left_in_row <= '0;
      rows_left   <= '0;
      odd_area    <= 1'b0;
    end else if (cmd.start) begin
      scan_active <= 1'b1;
      pos_x       <= PW'(x2);
      pos_y       <= PW'(y2);
      diag_step   <= s_diag;
      row_step_x  <= s_rsx;
      row_step_y  <= s_rsy;
      row_length  <= w_pos || w_neg ? half_w : '0;
      left_in_row <= w_pos || w_neg ? half_w : '0;
      rows_left   <= s_rows;
      odd_area    <= w[0] || !(w_pos || w_neg);
    end else if (cmd.finish) begin
      scan_active <= 1'b0;
    end else if (cmd.step) begin
      if (n_end) begin
        scan_active <= 1'b0;
      end else begin
        pos_x       <= nx;
        pos_y       <= ny;
        left_in_row <= n_left;
        rows_left   <= n_rows;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tile_index <= make_tile(x2, y2, lw);
      done_res   <= 1'b0;
    end else if (cmd.finish || (cmd.step && n_end)) begin
      tile_index <= '0;
      done_res   <= 1'b1;
    end else if (cmd.step && n_hit) begin
      tile_index <= make_tile(CW'(nx), CW'(ny), lw);
      done_res   <= 1'b0;
    end
  end

  assign status.req_type = req_q;
  assign status.active   = scan_active;
  assign status.step_hit = n_hit;
  assign status.step_end = n_end;

endmodule

`default_nettype wire

>>> src/diagonal_area_scan_generator_top.sv
// diagonal area scan generator: one result item per input item
// start item: after acceptance the decide state starts the scan, then the result is valid
// advance item: after acceptance and decide, the step loop moves past tiles outside the map
//   until it reaches a tile inside the map or the area runs out, then the result is valid;
//   the step loop is skipped when no scan is running
// next item is taken in the cycle its predecessor's result is taken
// synchronous reset: map size 8 by 8 log, no scan running, no result pending
`default_nettype none

module diagonal_area_scan_generator_top #(
  parameter int MAX_LOG_SIDE = dasg_pkg::MAX_LOG_SIDE_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_wr_en,
  input  wire [dasg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [dasg_pkg::LOG_REG_W-1:0]  cfg_data,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire                            req_type,
  input  wire [dasg_pkg::TILE_W-1:0]     corner_first,
  input  wire [dasg_pkg::TILE_W-1:0]     corner_second,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [dasg_pkg::TILE_W-1:0]    tile_index,
  output logic                           done_res
);
  import dasg_pkg::*;

  cmd_t    cmd;
  status_t status;

  dasg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  dasg_datapath #(
    .MAX_LOG_SIDE (MAX_LOG_SIDE)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (req_type),
    .corner_first  (corner_first),
    .corner_second (corner_second),
    .cmd           (cmd),
    .status        (status),
    .tile_index    (tile_index),
    .done_res      (done_res)
  );

endmodule

`default_nettype wire
